[hdl/c2e_pkg.sv]
package c2e_pkg;

  localparam int COORD_BITS = 16;
  localparam int ANGLE_BITS = 18;
  localparam int DIM_BITS   = 12;

  // coordinates are scaled so that each one fills a 32-bit word
  localparam int FRAC_BITS  = 32 - COORD_BITS;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int ROOT_W     = SQ_W / 2 + FRAC_BITS;
  localparam int REM_W      = ROOT_W + 4;
  localparam int SQRT_STEPS = ROOT_W;

  // cordic datapath: 32-bit operand, sign, half-turn fold and gain headroom
  localparam int CW         = 36;
  localparam int NITER      = (ANGLE_BITS > 32) ? 32 : ANGLE_BITS;
  localparam int ANGLE_SH   = 32 - NITER;
  localparam int PROD_W     = DIM_BITS + ANGLE_BITS + 1;

  localparam logic signed [CW-1:0] HALF_TURN = {{(CW-32){1'b0}}, 1'b1, 31'b0};
  localparam logic signed [CW-1:0] FULL_TURN = {{(CW-33){1'b0}}, 1'b1, 32'b0};
  localparam logic [33:0] ANGLE_RND = (ANGLE_SH > 0) ? (34'd1 << (ANGLE_SH - 1)) : 34'd0;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic [1:0] {
    CFG_AXIS_OFFSET  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic signed [COORD_BITS-1:0] z_coord;
  } c2e_in_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] column;
    logic [DIM_BITS-1:0] row;
    logic                degenerate;
    logic                last;
  } c2e_out_t;

  // one finished point waiting for the output side
  typedef struct packed {
    logic [DIM_BITS-1:0] column;
    logic [DIM_BITS-1:0] row;
    logic                degenerate;
    logic                wrap;
  } c2e_entry_t;

  function automatic logic [31:0] atan_ent(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h20000000;   1: v = 32'h12E4051E;   2: v = 32'h09FB385B;
      3: v = 32'h051111D4;   4: v = 32'h028B0D43;   5: v = 32'h0145D7E1;
      6: v = 32'h00A2F61E;   7: v = 32'h00517C55;   8: v = 32'h0028BE53;
      9: v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D; 16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30; 19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146; 22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029; 25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005; 28: v = 32'h00000003;  29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // image dimension clamped to [2, 2^DIM_BITS], minus one
  function automatic logic [DIM_BITS-1:0] dim_minus1(input logic [DIM_BITS:0] d);
    logic [DIM_BITS-1:0] v;
    if (d < (DIM_BITS+1)'(2)) begin
      v = DIM_BITS'(1);
    end else if (d > {1'b1, {DIM_BITS{1'b0}}}) begin
      v = {DIM_BITS{1'b1}};
    end else begin
      v = DIM_BITS'(d - (DIM_BITS+1)'(1));
    end
    return v;
  endfunction

  // turn fraction clamped to [0, 1] and rounded half up
  function automatic logic [ANGLE_BITS:0] angle_frac(input logic signed [CW-1:0] a);
    logic [32:0] u;
    logic [33:0] r;
    if (a < 0) begin
      u = '0;
    end else if (a > FULL_TURN) begin
      u = {1'b1, 32'b0};
    end else begin
      u = a[32:0];
    end
    r = {1'b0, u} + ANGLE_RND;
    return r[ANGLE_SH +: ANGLE_BITS+1];
  endfunction

endpackage

[hdl/c2e_isqrt.sv]
module c2e_isqrt import c2e_pkg::*; #(
  parameter int PASS_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [SQ_W-1:0]   sq_i,
  input  logic [PASS_W-1:0] pass_i,
  output logic              vld_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [PASS_W-1:0] pass_o
);

  // one result bit per stage; radicand is sq_i with 2*FRAC_BITS zero bits below
  logic              vld_r  [SQRT_STEPS];
  logic [REM_W-1:0]  rem_r  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_r [SQRT_STEPS];
  logic [SQ_W-1:0]   sq_r   [SQRT_STEPS];
  logic [PASS_W-1:0] pass_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic              vld_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W-1:0]   sq_in;
    logic [PASS_W-1:0] pass_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sq_in   = sq_i;
      assign pass_in = pass_i;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign sq_in   = sq_r[k-1];
      assign pass_in = pass_r[k-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], sq_in[SQ_W-1 -: 2]};
    assign trial  = REM_W'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k]   <= {sq_in[SQ_W-3:0], 2'b00};
        pass_r[k] <= pass_in;
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_o  = vld_r[SQRT_STEPS-1];
  assign root_o = root_r[SQRT_STEPS-1];
  assign pass_o = pass_r[SQRT_STEPS-1];

endmodule

[hdl/c2e_cordic.sv]
module c2e_cordic import c2e_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [CW-1:0] x_i [2],
  input  logic signed [CW-1:0] y_i [2],
  input  logic                 pass_i,
  output logic                 vld_o,
  output logic signed [CW-1:0] ang_o [2],
  output logic                 pass_o
);

  // two vectoring lanes side by side; stage 0 folds the left half plane
  logic                 vld_r  [NITER+1];
  logic                 pass_r [NITER+1];
  logic signed [CW-1:0] x_r    [NITER+1][2];
  logic signed [CW-1:0] y_r    [NITER+1][2];
  logic signed [CW-1:0] ang_r  [NITER+1][2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pass_r[0] <= pass_i;
      for (int l = 0; l < 2; l++) begin
        if (x_i[l] < 0) begin
          x_r[0][l]   <= -x_i[l];
          y_r[0][l]   <= -y_i[l];
          ang_r[0][l] <= (y_i[l] >= 0) ? HALF_TURN : -HALF_TURN;
        end else begin
          x_r[0][l]   <= x_i[l];
          y_r[0][l]   <= y_i[l];
          ang_r[0][l] <= '0;
        end
      end
    end
  end

  for (genvar i = 0; i < NITER; i++) begin : g_iter
    localparam logic signed [CW-1:0] ATN = CW'(atan_ent(i));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pass_r[i+1] <= pass_r[i];
        for (int l = 0; l < 2; l++) begin
          if (y_r[i][l] > 0) begin
            x_r[i+1][l]   <= x_r[i][l] + (y_r[i][l] >>> i);
            y_r[i+1][l]   <= y_r[i][l] - (x_r[i][l] >>> i);
            ang_r[i+1][l] <= ang_r[i][l] + ATN;
          end else if (y_r[i][l] < 0) begin
            x_r[i+1][l]   <= x_r[i][l] - (y_r[i][l] >>> i);
            y_r[i+1][l]   <= y_r[i][l] + (x_r[i][l] >>> i);
            ang_r[i+1][l] <= ang_r[i][l] - ATN;
          end else begin
            x_r[i+1][l]   <= x_r[i][l];
            y_r[i+1][l]   <= y_r[i][l];
            ang_r[i+1][l] <= ang_r[i][l];
          end
        end
      end
    end
  end

  assign vld_o    = vld_r[NITER];
  assign pass_o   = pass_r[NITER];
  assign ang_o[0] = ang_r[NITER][0];
  assign ang_o[1] = ang_r[NITER][1];

endmodule

[hdl/c2e_front.sv]
module c2e_front import c2e_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  c2e_in_t                      in_pt,
  input  logic signed [COORD_BITS-1:0] axis_offset,
  input  logic [DIM_BITS-1:0]          wm1,
  input  logic [DIM_BITS-1:0]          hm1,
  output logic                         push_vld,
  output c2e_entry_t                   push_entry
);

  localparam int PASS_W = 3 * COORD_BITS + 2;

  logic signed [COORD_BITS:0]   zoff;
  logic                         v0_r, v1_r, v2_r;
  logic signed [COORD_BITS-1:0] x0_r, y0_r, x1_r, y1_r, x2_r, y2_r;
  logic signed [COORD_BITS:0]   z0_r, z1_r, z2_r;
  logic                         d0_r, d1_r, d2_r;
  logic [SQ_W-1:0]              xx_r, yy_r, s_r;

  logic                         sq_vld;
  logic [ROOT_W-1:0]            rho;
  logic [PASS_W-1:0]            sq_pass;
  logic signed [COORD_BITS-1:0] xs, ys;
  logic signed [COORD_BITS:0]   zs;
  logic                         ds;

  logic signed [CW-1:0]         cx [2];
  logic signed [CW-1:0]         cy [2];
  logic signed [CW-1:0]         ang [2];
  logic                         c_vld, c_deg;

  logic                         v3_r, v4_r, d3_r, d4_r;
  logic [ANGLE_BITS:0]          fa_r, fp_r;
  logic [PROD_W-1:0]            cp_r, rp_r;
  logic [DIM_BITS-1:0]          wm1_r, col;

  assign zoff = {in_pt.z_coord[COORD_BITS-1], in_pt.z_coord}
              - {axis_offset[COORD_BITS-1], axis_offset};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_vld;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= in_pt.x_coord;
      y0_r <= in_pt.y_coord;
      z0_r <= zoff;
      d0_r <= (in_pt.x_coord == '0) && (in_pt.y_coord == '0) && (zoff == '0);
      xx_r <= SQ_W'(x0_r * x0_r);
      yy_r <= SQ_W'(y0_r * y0_r);
      x1_r <= x0_r;
      y1_r <= y0_r;
      z1_r <= z0_r;
      d1_r <= d0_r;
      s_r  <= xx_r + yy_r;
      x2_r <= x1_r;
      y2_r <= y1_r;
      z2_r <= z1_r;
      d2_r <= d1_r;
    end
  end

  c2e_isqrt #(.PASS_W(PASS_W)) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v2_r),
    .sq_i   (s_r),
    .pass_i ({x2_r, y2_r, z2_r, d2_r}),
    .vld_o  (sq_vld),
    .root_o (rho),
    .pass_o (sq_pass)
  );

  assign {xs, ys, zs, ds} = sq_pass;

  // lane 0 azimuth from (x, y), lane 1 polar angle from (zoff, rho)
  assign cx[0] = CW'(signed'({xs, {FRAC_BITS{1'b0}}}));
  assign cy[0] = CW'(signed'({ys, {FRAC_BITS{1'b0}}}));
  assign cx[1] = CW'(signed'({zs, {FRAC_BITS{1'b0}}}));
  assign cy[1] = signed'(CW'(rho));

  c2e_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (sq_vld),
    .x_i    (cx),
    .y_i    (cy),
    .pass_i (ds),
    .vld_o  (c_vld),
    .ang_o  (ang),
    .pass_o (c_deg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v3_r <= c_vld;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fa_r  <= angle_frac(ang[0] + HALF_TURN);
      fp_r  <= angle_frac(ang[1] <<< 1);
      d3_r  <= c_deg;
      cp_r  <= PROD_W'(wm1 * fa_r);
      rp_r  <= PROD_W'(hm1 * fp_r);
      wm1_r <= wm1;
      d4_r  <= d3_r;
    end
  end

  assign col = cp_r[ANGLE_BITS +: DIM_BITS];

  always_comb begin
    push_vld = v4_r && en;
    if (d4_r) begin
      push_entry.column     = '0;
      push_entry.row        = '0;
      push_entry.degenerate = 1'b1;
      push_entry.wrap       = 1'b0;
    end else begin
      push_entry.column     = col;
      push_entry.row        = rp_r[ANGLE_BITS +: DIM_BITS];
      push_entry.degenerate = 1'b0;
      push_entry.wrap       = (col == wm1_r);
    end
  end

endmodule

[hdl/c2e_queue.sv]
module c2e_queue import c2e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  c2e_entry_t push_entry,
  input  logic       pop,
  output c2e_entry_t pop_entry,
  output logic       empty,
  output logic       full
);

  c2e_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign pop_entry = mem_r[rd_ptr_r];
  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == (QPTR_W+1)'(QDEPTH));

endmodule

[hdl/c2e_back.sv]
module c2e_back import c2e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  c2e_entry_t q_entry,
  output logic       pop,
  output logic       out_strobe,
  output c2e_out_t   out_data
);

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_WRAP = 2'b10
  } bk_state_t;

  bk_state_t           state_r, state_nxt;
  logic                strobe_r, strobe_nxt;
  c2e_out_t            data_r, data_nxt;
  logic [DIM_BITS-1:0] col_r, row_r;

  always_comb begin
    pop        = 1'b0;
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    data_nxt   = data_r;
    unique case (state_r)
      ST_RUN: begin
        if (!q_empty) begin
          pop        = 1'b1;
          strobe_nxt = 1'b1;
          if (q_entry.wrap) begin
            data_nxt  = '{column: '0, row: q_entry.row, degenerate: 1'b0, last: 1'b0};
            state_nxt = ST_WRAP;
          end else begin
            data_nxt = '{column: q_entry.column, row: q_entry.row,
                         degenerate: q_entry.degenerate, last: 1'b1};
          end
        end
      end
      ST_WRAP: begin
        strobe_nxt = 1'b1;
        data_nxt   = '{column: col_r, row: row_r, degenerate: 1'b0, last: 1'b1};
        state_nxt  = ST_RUN;
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_RUN;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (pop) begin
      col_r <= q_entry.column;
      row_r <= q_entry.row;
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = data_r;

endmodule

[hdl/cartesian_to_equirect_pixel.sv]
// maps a signed point (x, y, z) to an equirectangular pixel: column from the
// azimuth atan2(y, x) + pi, row from the polar angle of (z - axis_offset)
// against the horizontal radius. a point is taken on a clock edge with start
// high and busy low, one point per cycle, and its results come out on
// out_strobe, one per cycle; the receiver cannot stall, so every
// strobed result must be captured. a point landing on the last column gives
// two results (column 0 first, then the last column, with last set on the
// second). the second result takes an extra output slot; the four-entry queue
// absorbs it and busy rises only while that queue is full. the point at the
// sphere centre gives one result with degenerate set and pixel 0. the
// datapath runs through the 32-step square root pipeline and the 19-stage
// cordic; config may only be written when no point is in flight.
module cartesian_to_equirect_pixel import c2e_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  c2e_in_t               in_data,
  output logic                  out_strobe,
  output c2e_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);

  // configuration registers
  logic signed [COORD_BITS-1:0] axis_offset_r;
  logic [DIM_BITS:0]            image_width_r, image_height_r;

  // front / back coupling
  logic       adv, push_vld, pop, q_empty, q_full;
  c2e_entry_t push_entry, q_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_offset_r  <= '0;
      image_width_r  <= (DIM_BITS+1)'(1024);
      image_height_r <= (DIM_BITS+1)'(512);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AXIS_OFFSET:  axis_offset_r  <= cfg_data;
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[DIM_BITS:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data[DIM_BITS:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // whole front pipeline moves when the queue can take its output
  assign adv  = !q_full || pop;
  assign busy = !adv;

  c2e_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_vld      (start && !busy),
    .in_pt       (in_data),
    .axis_offset (axis_offset_r),
    .wm1         (dim_minus1(image_width_r)),
    .hm1         (dim_minus1(image_height_r)),
    .push_vld    (push_vld),
    .push_entry  (push_entry)
  );

  c2e_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_vld),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (q_entry),
    .empty      (q_empty),
    .full       (q_full)
  );

  // back end emits one transfer per cycle while it has entries to send, two for a wrap column
  c2e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_entry    (q_entry),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
